// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion macros for the output checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion on clk, off during reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// plain implication on clk, checked during reset too
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/tev_pkg.sv -----
// ----------------------------------------------------------------------------
// tev_pkg
// Types and constants for the triangle extruder.
// ----------------------------------------------------------------------------
package tev_pkg;

	localparam int NSTEP = 15;
	localparam int NST   = NSTEP + 3;
	localparam int RW    = 68;
	localparam int NVERT = 15;

	localparam logic [5:0] SEL_MASK = 6'b100110;
	localparam logic [5:0] ZD_MASK  = 6'b110010;
	localparam logic signed [15:0] NORM_NEG_ONE = -16'sd16384;
	localparam logic [15:0] DEPTH_RESET = 16'd256;

	typedef struct packed {
		logic [2:0][15:0] px;
		logic [2:0][15:0] py;
		logic [15:0]      depth;
		logic [1:0]       dxneg;
		logic [1:0]       dypos;
		logic [1:0]       deg;
	} tri_t;

	typedef struct packed {
		logic signed [RW-1:0] r;
		logic signed [RW-1:0] p;
		logic [32:0]          l2;
		logic [14:0]          m;
	} lane_t;

endpackage

// ----- design/triangle_extrude_vertices.sv -----
// ----------------------------------------------------------------------------
// triangle_extrude_vertices
// Flow: a triangle runs through the normal pipeline, then the output sequencer latches it.
// Throughput: one vertex word per cycle while m_tready is high, set by the output sequencer;
// the 18-stage normal pipeline takes a triangle per cycle unless the sequencer stalls it.
// Normals: 15 shift/add stages, one magnitude bit each, four lanes in parallel.
// Reset: async, active low; clears valid bits and counters, depth to 256.
// ----------------------------------------------------------------------------
module triangle_extrude_vertices
	import tev_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [15:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [95:0]  s_tdata,   // ax, ay, bx, by_coord, cx, cy
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,   // pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y, norm_z
	output logic [1:0]   m_tuser,   // side_face, degenerate
	output logic         m_tlast
);

	logic [15:0] depth_q;
	logic        v_s [NST];
	tri_t        tri_s [NST];
	logic [1:0][1:0][15:0] abs_s1;
	logic [1:0][1:0][31:0] sq_s2;
	lane_t       lane_s [2:NST-1][4];

	logic        advance, take;
	logic        busy_q;
	logic [3:0]  cnt_q;
	tri_t        hold_q;
	logic [1:0][15:0] nx_q, ny_q;

	tri_t        tin;
	logic [1:0][1:0][15:0] abs_in;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= DEPTH_RESET;
		end else if (cfg_valid) begin
			depth_q <= cfg_data;
		end
	end

	// input decode, edge differences
	always_comb begin
		logic signed [16:0] dx, dy;
		tin = '0;
		abs_in = '0;
		for (int i = 0; i < 3; i++) begin
			tin.px[i] = s_tdata[32*i +: 16];
			tin.py[i] = s_tdata[32*i+16 +: 16];
		end
		tin.depth = depth_q;
		for (int e = 0; e < 2; e++) begin
			dx = $signed({tin.px[e+1][15], tin.px[e+1]}) - $signed({tin.px[e][15], tin.px[e]});
			dy = $signed({tin.py[e+1][15], tin.py[e+1]}) - $signed({tin.py[e][15], tin.py[e]});
			tin.dxneg[e] = dx[16];
			tin.dypos[e] = !dy[16] && (dy != 17'sd0);
			tin.deg[e]   = (depth_q == 16'd0) || (dx == 17'sd0 && dy == 17'sd0);
			abs_in[e][0] = dx[16] ? 16'(-dx) : dx[15:0];
			abs_in[e][1] = dy[16] ? 16'(-dy) : dy[15:0];
		end
	end

	assign take    = v_s[NST-1] && (!busy_q || (m_tready && cnt_q == 4'(NVERT-1)));
	assign advance = !v_s[NST-1] || take;
	assign s_tready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NST; i++) v_s[i] <= 1'b0;
		end else if (advance) begin
			v_s[0] <= s_tvalid;
			for (int i = 1; i < NST; i++) v_s[i] <= v_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			tri_s[0] <= tin;
			abs_s1   <= abs_in;
			for (int i = 1; i < NST; i++) tri_s[i] <= tri_s[i-1];
			for (int e = 0; e < 2; e++) begin
				sq_s2[e][0] <= abs_s1[e][0] * abs_s1[e][0];
				sq_s2[e][1] <= abs_s1[e][1] * abs_s1[e][1];
			end
		end
	end

	// lane init: lane 2e -> |nx| (v = |dy|), lane 2e+1 -> |ny| (v = |dx|)
	// then one magnitude bit per stage, MSB first
	always_ff @(posedge clk) begin
		logic [32:0] l2;
		logic signed [RW-1:0] l2x, tr;
		lane_t nxt;
		int k;
		if (advance) begin
			for (int e = 0; e < 2; e++) begin
				l2 = {1'b0, sq_s2[e][0]} + {1'b0, sq_s2[e][1]};
				for (int c = 0; c < 2; c++) begin
					lane_s[2][2*e+c].l2 <= l2;
					lane_s[2][2*e+c].m  <= '0;
					lane_s[2][2*e+c].p  <= -$signed({{(RW-33){1'b0}}, l2});
					lane_s[2][2*e+c].r  <= $signed({{(RW-62){1'b0}}, sq_s2[e][1-c], 30'd0})
						- $signed({{(RW-33){1'b0}}, l2});
				end
			end
			for (int j = 0; j < NSTEP; j++) begin
				k = NSTEP - 1 - j;
				for (int n = 0; n < 4; n++) begin
					nxt = lane_s[2+j][n];
					l2x = $signed({{(RW-33){1'b0}}, nxt.l2});
					tr  = nxt.r - ((nxt.p <<< (k+2)) + (l2x <<< (2*k+2)));
					if (!tr[RW-1]) begin
						nxt.r    = tr;
						nxt.p    = nxt.p + (l2x <<< (k+1));
						nxt.m[k] = 1'b1;
					end
					lane_s[3+j][n] <= nxt;
				end
			end
		end
	end

	// output sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (take) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q && m_tready) begin
			if (cnt_q == 4'(NVERT-1)) begin
				busy_q <= 1'b0;
				cnt_q  <= '0;
			end else begin
				cnt_q <= cnt_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		logic [15:0] mx, my;
		logic        dneg;
		if (take) begin
			hold_q <= tri_s[NST-1];
			dneg = tri_s[NST-1].depth[15];
			for (int e = 0; e < 2; e++) begin
				mx = {1'b0, lane_s[NST-1][2*e].m};
				my = {1'b0, lane_s[NST-1][2*e+1].m};
				if (tri_s[NST-1].deg[e]) begin
					nx_q[e] <= '0;
					ny_q[e] <= '0;
				end else begin
					nx_q[e] <= (tri_s[NST-1].dypos[e] != dneg) ? -mx : mx;
					ny_q[e] <= (tri_s[NST-1].dxneg[e] != dneg) ? -my : my;
				end
			end
		end
	end

	always_comb begin
		logic        side, e;
		logic [2:0]  vi;
		logic [1:0]  pi;
		logic [15:0] x, y, z, tv, nx, ny, nz;
		side = cnt_q >= 4'd3;
		e    = cnt_q >= 4'd9;
		vi   = 3'(cnt_q - (e ? 4'd9 : 4'd3));
		if (!side) begin
			pi = cnt_q[1:0];
			z  = '0;
			tv = hold_q.py[pi];
			nx = '0;
			ny = '0;
			nz = NORM_NEG_ONE;
		end else begin
			pi = {1'b0, e} + {1'b0, SEL_MASK[vi]};
			z  = ZD_MASK[vi] ? hold_q.depth : 16'd0;
			tv = z;
			nx = nx_q[e];
			ny = ny_q[e];
			nz = '0;
		end
		x = hold_q.px[pi];
		y = hold_q.py[pi];
		m_tdata = {nz, ny, nx, tv, x, z, y, x};
		m_tuser = {side && hold_q.deg[e], side};
		m_tlast = cnt_q == 4'(NVERT-1);
	end

	assign m_tvalid = busy_q;

endmodule

// ----- design/tev_checker.sv -----
// ----------------------------------------------------------------------------
// tev_checker
// Port-level checks on the vertex output of the triangle extruder.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tev_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [127:0] m_tdata,
	input logic [1:0]   m_tuser,
	input logic         m_tlast
);

	`ASSERT_CLK(a_valid_hold, m_tvalid && !m_tready |=> m_tvalid, "output word dropped")
	`ASSERT_CLK(a_data_hold, m_tvalid && !m_tready |=> $stable(m_tdata), "stalled word changed")
	`ASSERT_CLK(a_last_side, m_tvalid && m_tlast |-> m_tuser[0], "last vertex not a side vertex")
	`ASSERT_CLK(a_front_norm, m_tvalid && !m_tuser[0] |-> m_tdata[127:112] == 16'hC000 && !m_tuser[1], "front normal wrong")
	`ASSERT_CLK(a_deg_zero, m_tvalid && m_tuser[1] |-> m_tdata[95:80] == 16'd0 && m_tdata[111:96] == 16'd0, "degenerate normal not zero")

endmodule

bind triangle_extrude_vertices tev_checker u_tev_checker (.*);
